@@ sv/nds_pkg.sv @@
// Shared types and constants for the navigation decision sequencer.
// No dependencies; used by nds_step, the top level and the port checker.
package nds_pkg;

   localparam int unsigned WaitW   = 16;
   localparam int unsigned TicksW  = 32;
   localparam int unsigned TrialsW = 16;
   localparam int unsigned DtW     = 13;
   localparam int unsigned CsrIdxW = 2;
   localparam int unsigned CsrDataW = 16;

   localparam logic [WaitW-1:0] PunishWait    = 16'd96;
   localparam logic [WaitW-1:0] IntersectWait = 16'd2;
   localparam logic [DtW-1:0]   DecisionTimeReset = 13'd100;

   typedef enum logic [2:0] {
      MODE_CRUISE    = 3'd0,
      MODE_INTERSECT = 3'd1,
      MODE_DECIDE    = 3'd2,
      MODE_DECIDED   = 3'd3,
      MODE_GOAL      = 3'd4,
      MODE_BLOCK     = 3'd5,
      MODE_SLEEP     = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      MOTOR_STOP     = 2'd0,
      MOTOR_STRAIGHT = 2'd1,
      MOTOR_HEADING  = 2'd2
   } motor_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SLEEP_STEPS   = 2'd0,
      CSR_DEC_TICKS     = 2'd1,
      CSR_JUNCTION_ONLY = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [WaitW-1:0] sleep_steps;
      logic [DtW-1:0]   dec_ticks;
      logic             junction_only;
   } cfg_type;

   typedef struct packed {
      logic             sleep_request;
      logic             at_goal;
      logic             blocked;
      logic [3:0]       open_paths;
   } req_type;

   typedef struct packed {
      mode_type          mode;
      logic [WaitW-1:0]  wait_cnt;
      logic [TicksW-1:0] trial_ticks;
      logic [TrialsW-1:0] goal_cnt;
   } state_type;

   typedef struct packed {
      mode_type           mode;
      logic               learn_enable;
      logic               plan_enable;
      logic               reward_pulse;
      logic               punish_pulse;
      logic               sleeping;
      logic [WaitW-1:0]   wait_before;
      logic               decide_strobe;
      motor_type          motor_cmd;
      logic [TrialsW-1:0] trial_count;
      logic [TicksW-1:0]  trial_steps;
   } rsp_type;

endpackage

@@ sv/nds_step.sv @@
// One control tick: enables and pulses from the old state, prioritized mode
// transition, motor command and saturating trial counters. Uses nds_pkg.
module nds_step (
   input  nds_pkg::state_type st,
   input  nds_pkg::cfg_type   cfg,
   input  nds_pkg::req_type   req,
   output nds_pkg::state_type st_next,
   output nds_pkg::rsp_type   rsp
);

   nds_pkg::mode_type            om;
   logic [nds_pkg::WaitW-1:0]    ow;
   logic [nds_pkg::WaitW-1:0]    dt16;
   logic [nds_pkg::WaitW-1:0]    dt2;
   logic [nds_pkg::WaitW-1:0]    dt5;
   logic [3:0]                   ways;
   logic [nds_pkg::TicksW-1:0]   ticks_inc;
   logic                         strobe;

   assign om   = st.mode;
   assign ow   = st.wait_cnt;
   assign dt16 = {3'b000, cfg.dec_ticks};
   assign dt2  = dt16 << 1;
   assign dt5  = (dt16 << 2) + dt16;
   assign ways = (om == nds_pkg::MODE_SLEEP) ? 4'd0 : req.open_paths;
   assign ticks_inc = (&st.trial_ticks) ? st.trial_ticks
                                        : st.trial_ticks + 32'd1;

   always_comb begin
      st_next             = st;
      st_next.trial_ticks = ticks_inc;
      strobe              = 1'b0;
      priority if (om != nds_pkg::MODE_SLEEP && cfg.sleep_steps != '0 &&
                   req.sleep_request) begin
         st_next.wait_cnt = cfg.sleep_steps;
         st_next.mode     = nds_pkg::MODE_SLEEP;
      end else if (om == nds_pkg::MODE_SLEEP && ow == '0) begin
         st_next.mode = nds_pkg::MODE_CRUISE;
      end else if (om != nds_pkg::MODE_GOAL && om != nds_pkg::MODE_SLEEP &&
                   req.at_goal) begin
         st_next.wait_cnt    = dt5;
         st_next.mode        = nds_pkg::MODE_GOAL;
         st_next.trial_ticks = '0;
         if (!(&st.goal_cnt)) begin
            st_next.goal_cnt = st.goal_cnt + 16'd1;
         end
      end else if (om == nds_pkg::MODE_GOAL && ow == '0) begin
         st_next.mode = nds_pkg::MODE_CRUISE;
      end else if (om != nds_pkg::MODE_BLOCK && om != nds_pkg::MODE_SLEEP &&
                   om != nds_pkg::MODE_GOAL && req.blocked) begin
         st_next.wait_cnt = dt2;
         st_next.mode     = nds_pkg::MODE_BLOCK;
      end else if (om == nds_pkg::MODE_BLOCK && ow == '0) begin
         st_next.mode = nds_pkg::MODE_CRUISE;
      end else if (om == nds_pkg::MODE_CRUISE && ways > 4'd1) begin
         st_next.mode     = nds_pkg::MODE_INTERSECT;
         st_next.wait_cnt = nds_pkg::IntersectWait;
      end else if (om == nds_pkg::MODE_INTERSECT && ow == '0) begin
         st_next.wait_cnt = cfg.junction_only ? (dt16 >> 1) : '0;
         st_next.mode     = nds_pkg::MODE_DECIDE;
      end else if (om == nds_pkg::MODE_DECIDE && ow == '0) begin
         st_next.mode     = nds_pkg::MODE_DECIDED;
         st_next.wait_cnt = dt16;
         strobe           = 1'b1;
      end else if (om == nds_pkg::MODE_DECIDED && ow == '0) begin
         st_next.mode = nds_pkg::MODE_CRUISE;
      end else begin
         if (ow != '0) begin
            st_next.wait_cnt = ow - 16'd1;
         end
      end
   end

   always_comb begin
      rsp.mode          = st_next.mode;
      rsp.learn_enable  = !(om == nds_pkg::MODE_GOAL && ow != '0);
      rsp.plan_enable   = cfg.junction_only ? (om == nds_pkg::MODE_DECIDE) : 1'b1;
      rsp.reward_pulse  = (om == nds_pkg::MODE_GOAL) && (ow == dt5);
      rsp.punish_pulse  = (om == nds_pkg::MODE_BLOCK) && (ow == nds_pkg::PunishWait);
      rsp.sleeping      = (om == nds_pkg::MODE_SLEEP);
      rsp.wait_before   = ow;
      rsp.decide_strobe = strobe;
      rsp.trial_count   = st_next.goal_cnt;
      rsp.trial_steps   = st_next.trial_ticks;
      unique case (st_next.mode)
         nds_pkg::MODE_GOAL,
         nds_pkg::MODE_DECIDE,
         nds_pkg::MODE_SLEEP:   rsp.motor_cmd = nds_pkg::MOTOR_STOP;
         nds_pkg::MODE_DECIDED: rsp.motor_cmd = nds_pkg::MOTOR_HEADING;
         default:               rsp.motor_cmd = nds_pkg::MOTOR_STRAIGHT;
      endcase
   end

endmodule

@@ sv/navigation_decision_sequencer_core.sv @@
// Top level of the navigation decision sequencer: config registers, request
// register, controller state and result register. Uses nds_pkg and nds_step.
//
// Usage:
//   Each request on the req_ channel is one control tick carrying the sensor
//   flags and the free pathway count. It is taken when req_valid is high and
//   req_stall is low. Every request yields exactly one result on the rsp_
//   channel, taken when rsp_valid is high and rsp_stall is low.
//   The request is registered, the tick is evaluated against the controller
//   state and the result is registered. Throughput is one request per cycle
//   while rsp_stall is low; the tick logic is a single pass between the
//   request register and the result register.
//   While a result is stalled, one further request is held in the request
//   register; req_stall rises only when both registers are full and
//   rsp_stall is high.
//   Reset empties both registers, returns the controller to cruise with a
//   zero wait and zero trial counters, and loads the config defaults
//   (sleep steps 0, decision time 100, junction-only planning on). csr_ writes
//   are taken in any cycle and should be made while the block is idle.
module navigation_decision_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_sleep_request,
   input  logic        req_at_goal,
   input  logic        req_blocked,
   input  logic [3:0]  req_open_paths,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_mode,
   output logic        rsp_learn_enable,
   output logic        rsp_plan_enable,
   output logic        rsp_reward_pulse,
   output logic        rsp_punish_pulse,
   output logic        rsp_sleeping,
   output logic [15:0] rsp_wait_before,
   output logic        rsp_decide_strobe,
   output logic [1:0]  rsp_motor_cmd,
   output logic [15:0] rsp_trial_count,
   output logic [31:0] rsp_trial_steps
);

   nds_pkg::cfg_type   cfg_ff;
   nds_pkg::req_type   req_ff;
   logic               req_valid_ff;
   nds_pkg::state_type st_ff;
   nds_pkg::state_type st_in;
   nds_pkg::rsp_type   rsp_ff;
   nds_pkg::rsp_type   rsp_in;
   logic               rsp_valid_ff;
   logic               out_free;
   logic               advance;
   logic               req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sleep_steps   <= '0;
         cfg_ff.dec_ticks     <= nds_pkg::DecisionTimeReset;
         cfg_ff.junction_only <= 1'b1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            nds_pkg::CSR_SLEEP_STEPS:   cfg_ff.sleep_steps   <= csr_wdata;
            nds_pkg::CSR_DEC_TICKS:     cfg_ff.dec_ticks     <= csr_wdata[12:0];
            nds_pkg::CSR_JUNCTION_ONLY: cfg_ff.junction_only <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.sleep_request <= req_sleep_request;
         req_ff.at_goal       <= req_at_goal;
         req_ff.blocked       <= req_blocked;
         req_ff.open_paths    <= req_open_paths;
      end
   end

   nds_step u_step (
      .st      (st_ff),
      .cfg     (cfg_ff),
      .req     (req_ff),
      .st_next (st_in),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode        <= nds_pkg::MODE_CRUISE;
         st_ff.wait_cnt    <= '0;
         st_ff.trial_ticks <= '0;
         st_ff.goal_cnt    <= '0;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode          = rsp_ff.mode;
   assign rsp_learn_enable  = rsp_ff.learn_enable;
   assign rsp_plan_enable   = rsp_ff.plan_enable;
   assign rsp_reward_pulse  = rsp_ff.reward_pulse;
   assign rsp_punish_pulse  = rsp_ff.punish_pulse;
   assign rsp_sleeping      = rsp_ff.sleeping;
   assign rsp_wait_before   = rsp_ff.wait_before;
   assign rsp_decide_strobe = rsp_ff.decide_strobe;
   assign rsp_motor_cmd     = rsp_ff.motor_cmd;
   assign rsp_trial_count   = rsp_ff.trial_count;
   assign rsp_trial_steps   = rsp_ff.trial_steps;

endmodule

@@ sv/nds_port_checker.sv @@
// Port-level checks for the navigation decision sequencer top level.
// Uses nds_pkg; attached to navigation_decision_sequencer_core by bind.
module nds_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_mode,
   input logic        rsp_learn_enable,
   input logic        rsp_reward_pulse,
   input logic        rsp_punish_pulse,
   input logic        rsp_sleeping,
   input logic [15:0] rsp_wait_before,
   input logic        rsp_decide_strobe,
   input logic [1:0]  rsp_motor_cmd,
   input logic [31:0] rsp_trial_steps
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mode) &&
         $stable(rsp_trial_steps))
      else $error("stalled result changed");

   a_strobe_heading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_decide_strobe |->
         rsp_mode == nds_pkg::MODE_DECIDED && rsp_motor_cmd == nds_pkg::MOTOR_HEADING)
      else $error("decide strobe without decided mode and heading command");

   a_punish_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_punish_pulse |->
         rsp_wait_before == nds_pkg::PunishWait && !rsp_sleeping &&
         !rsp_reward_pulse && rsp_learn_enable)
      else $error("punish pulse outside block mode");

   a_stop_modes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_motor_cmd == nds_pkg::MOTOR_STOP) ==
         (rsp_mode == nds_pkg::MODE_GOAL || rsp_mode == nds_pkg::MODE_DECIDE ||
          rsp_mode == nds_pkg::MODE_SLEEP))
      else $error("motor stop does not match mode");

endmodule

bind navigation_decision_sequencer_core nds_port_checker u_nds_port_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_mode          (rsp_mode),
   .rsp_learn_enable  (rsp_learn_enable),
   .rsp_reward_pulse  (rsp_reward_pulse),
   .rsp_punish_pulse  (rsp_punish_pulse),
   .rsp_sleeping      (rsp_sleeping),
   .rsp_wait_before   (rsp_wait_before),
   .rsp_decide_strobe (rsp_decide_strobe),
   .rsp_motor_cmd     (rsp_motor_cmd),
   .rsp_trial_steps   (rsp_trial_steps)
);

@@ tb/sv/navigation_decision_sequencer_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for navigation_decision_sequencer_core: a cycle model of the
// controller predicts every result, which is compared field by field on the rsp_ channel.
// Depends on nds_pkg and the core; random handshakes with idling on both sides.
module navigation_decision_sequencer_core_tb;

   localparam logic [1:0] CsrUnusedIdx = 2'd3;
   localparam int QuietLimit = 500;
   localparam int MaxReports = 10;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_stall;
   logic        req_sleep_request;
   logic        req_at_goal;
   logic        req_blocked;
   logic [3:0]  req_open_paths;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_mode;
   logic        rsp_learn_enable;
   logic        rsp_plan_enable;
   logic        rsp_reward_pulse;
   logic        rsp_punish_pulse;
   logic        rsp_sleeping;
   logic [15:0] rsp_wait_before;
   logic        rsp_decide_strobe;
   logic [1:0]  rsp_motor_cmd;
   logic [15:0] rsp_trial_count;
   logic [31:0] rsp_trial_steps;

   // controller model state and its register copy
   nds_pkg::mode_type                ctl_mode  = nds_pkg::MODE_CRUISE;
   logic [nds_pkg::WaitW-1:0]        ctl_wait  = '0;
   logic [nds_pkg::TicksW-1:0]       ctl_ticks = '0;
   logic [nds_pkg::TrialsW-1:0]      ctl_goals = '0;
   nds_pkg::cfg_type                 cfg       = '{16'd0, nds_pkg::DecisionTimeReset, 1'b1};

   nds_pkg::rsp_type pending_decisions[$];
   bit      req_idle = 1'b0;
   bit      rsp_idle = 1'b0;
   int      fail_count = 0;
   int      quiet_cycles = 0;

   navigation_decision_sequencer_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sleep_request (req_sleep_request),
      .req_at_goal       (req_at_goal),
      .req_blocked       (req_blocked),
      .req_open_paths    (req_open_paths),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_mode          (rsp_mode),
      .rsp_learn_enable  (rsp_learn_enable),
      .rsp_plan_enable   (rsp_plan_enable),
      .rsp_reward_pulse  (rsp_reward_pulse),
      .rsp_punish_pulse  (rsp_punish_pulse),
      .rsp_sleeping      (rsp_sleeping),
      .rsp_wait_before   (rsp_wait_before),
      .rsp_decide_strobe (rsp_decide_strobe),
      .rsp_motor_cmd     (rsp_motor_cmd),
      .rsp_trial_count   (rsp_trial_count),
      .rsp_trial_steps   (rsp_trial_steps)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic nds_pkg::rsp_type advance_controller(input nds_pkg::req_type t);
      nds_pkg::rsp_type          o;
      nds_pkg::mode_type         om;
      logic [nds_pkg::WaitW-1:0] ow;
      logic [nds_pkg::WaitW-1:0] goal_wait;
      logic [3:0]                ways;
      om = ctl_mode;
      ow = ctl_wait;
      ways = t.open_paths;
      goal_wait = 16'(32'(cfg.dec_ticks) * 5);
      o = '0;
      if (ctl_ticks != '1) ctl_ticks++;
      if (om == nds_pkg::MODE_SLEEP) ways = '0;

      o.learn_enable = !(om == nds_pkg::MODE_GOAL && ow != 0);
      o.plan_enable  = cfg.junction_only ? (om == nds_pkg::MODE_DECIDE) : 1'b1;
      o.reward_pulse = (om == nds_pkg::MODE_GOAL && ow == goal_wait);
      o.punish_pulse = (om == nds_pkg::MODE_BLOCK && ow == nds_pkg::PunishWait);
      o.sleeping     = (om == nds_pkg::MODE_SLEEP);
      o.wait_before  = ow;

      if (om != nds_pkg::MODE_SLEEP && cfg.sleep_steps != 0 && t.sleep_request) begin
         ctl_wait = cfg.sleep_steps;
         ctl_mode = nds_pkg::MODE_SLEEP;
      end else if (om == nds_pkg::MODE_SLEEP && ow == 0) begin
         ctl_mode = nds_pkg::MODE_CRUISE;
      end else if (om != nds_pkg::MODE_GOAL && om != nds_pkg::MODE_SLEEP && t.at_goal) begin
         ctl_wait = goal_wait;
         ctl_mode = nds_pkg::MODE_GOAL;
         ctl_ticks = '0;
         if (ctl_goals != '1) ctl_goals++;
      end else if (om == nds_pkg::MODE_GOAL && ow == 0) begin
         ctl_mode = nds_pkg::MODE_CRUISE;
      end else if (om != nds_pkg::MODE_BLOCK && om != nds_pkg::MODE_SLEEP &&
                   om != nds_pkg::MODE_GOAL && t.blocked) begin
         ctl_wait = 16'({cfg.dec_ticks, 1'b0});
         ctl_mode = nds_pkg::MODE_BLOCK;
      end else if (om == nds_pkg::MODE_BLOCK && ow == 0) begin
         ctl_mode = nds_pkg::MODE_CRUISE;
      end else if (om == nds_pkg::MODE_CRUISE && ways > 1) begin
         ctl_mode = nds_pkg::MODE_INTERSECT;
         ctl_wait = nds_pkg::IntersectWait;
      end else if (om == nds_pkg::MODE_INTERSECT && ow == 0) begin
         ctl_wait = cfg.junction_only ? 16'(cfg.dec_ticks >> 1) : '0;
         ctl_mode = nds_pkg::MODE_DECIDE;
      end else if (om == nds_pkg::MODE_DECIDE && ow == 0) begin
         ctl_mode = nds_pkg::MODE_DECIDED;
         ctl_wait = 16'(cfg.dec_ticks);
         o.decide_strobe = 1'b1;
      end else if (om == nds_pkg::MODE_DECIDED && ow == 0) begin
         ctl_mode = nds_pkg::MODE_CRUISE;
      end else if (ow != 0) begin
         ctl_wait = ow - 1'b1;
      end

      case (ctl_mode)
         nds_pkg::MODE_GOAL, nds_pkg::MODE_DECIDE, nds_pkg::MODE_SLEEP:
            o.motor_cmd = nds_pkg::MOTOR_STOP;
         nds_pkg::MODE_DECIDED: o.motor_cmd = nds_pkg::MOTOR_HEADING;
         default: o.motor_cmd = nds_pkg::MOTOR_STRAIGHT;
      endcase
      o.mode        = ctl_mode;
      o.trial_count = ctl_goals;
      o.trial_steps = ctl_ticks;
      return o;
   endfunction

   function automatic nds_pkg::req_type make_tick(input logic s, input logic g, input logic b,
                                                  input logic [3:0] w);
      nds_pkg::req_type t;
      t.sleep_request = s;
      t.at_goal       = g;
      t.blocked       = b;
      t.open_paths    = w;
      return t;
   endfunction

   // mostly rare flags with random pathway counts, some pure noise
   function automatic nds_pkg::req_type random_tick();
      nds_pkg::req_type t;
      if ($urandom_range(9, 0) == 0) begin
         t = nds_pkg::req_type'(7'($urandom));
      end else begin
         t.sleep_request = ($urandom_range(49, 0) == 0);
         t.at_goal       = ($urandom_range(49, 0) == 0);
         t.blocked       = ($urandom_range(24, 0) == 0);
         t.open_paths    = ($urandom_range(1, 0) != 0) ? 4'($urandom_range(1, 0))
                                                       : 4'($urandom);
      end
      return t;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MaxReports) $display("MISMATCH: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want)
         note_failure($sformatf("%s expected %0h actual %0h", name, want, got));
   endtask

   task automatic send_tick(input nds_pkg::req_type t);
      int gap;
      gap = req_idle ? $urandom_range(11, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_sleep_request <= t.sleep_request;
      req_at_goal       <= t.at_goal;
      req_blocked       <= t.blocked;
      req_open_paths    <= t.open_paths;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_decisions.insert(pending_decisions.size(), advance_controller(t));
   endtask

   task automatic run_until(input nds_pkg::mode_type target);
      bit keep_req;
      bit keep_rsp;
      keep_req = req_idle;
      keep_rsp = rsp_idle;
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      while (ctl_mode != target) send_tick('0);
      req_idle = keep_req;
      rsp_idle = keep_rsp;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         nds_pkg::CSR_SLEEP_STEPS:   cfg.sleep_steps   = data;
         nds_pkg::CSR_DEC_TICKS:     cfg.dec_ticks     = data[nds_pkg::DtW-1:0];
         nds_pkg::CSR_JUNCTION_ONLY: cfg.junction_only = data[0];
         default: ;
      endcase
   endtask

   // raw values may carry upper bits that the registers drop
   task automatic configure(input logic [15:0] sleep_raw, input logic [15:0] dt_raw,
                            input logic [15:0] flag_raw);
      wait_drained();
      write_reg(nds_pkg::CSR_SLEEP_STEPS, sleep_raw);
      write_reg(nds_pkg::CSR_DEC_TICKS, dt_raw);
      write_reg(nds_pkg::CSR_JUNCTION_ONLY, flag_raw);
      write_reg(CsrUnusedIdx, 16'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd1));
      send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd15));
      run_until(nds_pkg::MODE_DECIDED);
      send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd15));
      run_until(nds_pkg::MODE_CRUISE);
      send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd15));
      send_tick(make_tick(1'b0, 1'b1, 1'b1, 4'd0));
   endtask

   task automatic test_decision_extremes();
      req_idle = 1'b1;
      rsp_idle = 1'b0;
      configure(16'd1, {3'b111, 13'd8191}, 16'hFFFE);
      // sleep cuts the goal wait short
      send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0));
      run_until(nds_pkg::MODE_CRUISE);
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd8));
      send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0));
      send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd15));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd15));
      run_until(nds_pkg::MODE_CRUISE);
      send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd4));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd0));
      send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0));
      run_until(nds_pkg::MODE_CRUISE);
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd2));
      run_until(nds_pkg::MODE_DECIDED);
      send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0));
      run_until(nds_pkg::MODE_CRUISE);

      rsp_idle = 1'b1;
      configure(16'd3, 16'd0, 16'd1);
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd15));
      run_until(nds_pkg::MODE_CRUISE);
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd0));
      send_tick(make_tick(1'b0, 1'b1, 1'b1, 4'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b0, 4'd0));

      configure(16'd2, 16'd48, 16'd1);
      send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd0));
      send_tick(make_tick(1'b0, 1'b0, 1'b1, 4'd3));
      send_tick(make_tick(1'b0, 1'b1, 1'b0, 4'd0));
      send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0));
      send_tick(make_tick(1'b1, 1'b1, 1'b1, 4'd9));
      run_until(nds_pkg::MODE_CRUISE);
   endtask

   // full-scale sleep; once it takes the sleep request, the controller stays asleep to the end of the run
   task automatic test_long_sleep();
      configure(16'hFFFF, 16'd5, 16'd1);
      send_tick(make_tick(1'b1, 1'b0, 1'b0, 4'd0));
      repeat (30) send_tick(random_tick());
   endtask

   task automatic test_random_traffic();
      logic [12:0] dt;
      repeat (7) begin
         dt = ($urandom_range(3, 0) == 0) ? 13'($urandom_range(52, 48))
                                          : 13'($urandom_range(12, 0));
         configure(($urandom_range(3, 0) == 0) ? 16'd0 : 16'($urandom_range(20, 1)),
                   {3'($urandom), dt}, {15'($urandom), 1'($urandom)});
         repeat (2) begin
            req_idle = ($urandom_range(2, 0) != 0);
            rsp_idle = ($urandom_range(2, 0) != 0);
            repeat (25) send_tick(random_tick());
         end
      end
   endtask

   initial begin : result_checker
      int               gap;
      nds_pkg::rsp_type want;
      rsp_stall <= 1'b0;
      forever begin
         gap = rsp_idle ? $urandom_range(11, 0) : 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_decisions.size() == 0) begin
            note_failure("result with no request outstanding");
         end else begin
            want = pending_decisions.pop_front();
            check_field("mode", want.mode, rsp_mode);
            check_field("learn_enable", want.learn_enable, rsp_learn_enable);
            check_field("plan_enable", want.plan_enable, rsp_plan_enable);
            check_field("reward_pulse", want.reward_pulse, rsp_reward_pulse);
            check_field("punish_pulse", want.punish_pulse, rsp_punish_pulse);
            check_field("sleeping", want.sleeping, rsp_sleeping);
            check_field("wait_before", want.wait_before, rsp_wait_before);
            check_field("decide_strobe", want.decide_strobe, rsp_decide_strobe);
            check_field("motor_cmd", want.motor_cmd, rsp_motor_cmd);
            check_field("trial_count", want.trial_count, rsp_trial_count);
            check_field("trial_steps", want.trial_steps, rsp_trial_steps);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_valid         <= 1'b0;
      req_sleep_request <= 1'b0;
      req_at_goal       <= 1'b0;
      req_blocked       <= 1'b0;
      req_open_paths    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_decision_extremes();
      test_random_traffic();
      test_long_sleep();

      wait_drained();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/nds_pkg.sv
sv/nds_step.sv
sv/navigation_decision_sequencer_core.sv
sv/nds_port_checker.sv
tb/sv/navigation_decision_sequencer_core_tb.sv
